@@ hw/rtl/round_robin_task_scheduler_macros.svh @@
// Assertion macros shared by the round robin task scheduler RTL.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RRTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define RRTS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) ante |-> cons) else $error(msg);

`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) ante |=> cons) else $error(msg);

`else

`define RRTS_ASSERT(lbl, prop, msg)

`define RRTS_ASSERT_IMPL(lbl, ante, cons, msg)

`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ hw/rtl/rrts_pkg.sv @@
// Package with the types and constants of the round robin task scheduler.
package rrts_pkg;

    localparam int TASK_SLOTS_DEF = 8;
    localparam int WAKE_W         = 32;
    localparam int SECS_W         = 16;
    localparam int FUNC_W         = 3;
    localparam int OUT_SLOT_W     = 3;
    localparam int S_TDATA_W      = 16;
    localparam int S_TUSER_W      = FUNC_W;
    localparam int M_FIELDS_W     = 3 * OUT_SLOT_W + 1;
    localparam int M_TDATA_W      = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W        = M_TDATA_W - M_FIELDS_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK     = 3'd0,
        FUNC_SCHEDULE = 3'd1,
        FUNC_SLEEP    = 3'd2,
        FUNC_KILL     = 3'd3,
        FUNC_CREATE   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        SLOT_DEAD     = 2'd0,
        SLOT_READY    = 2'd1,
        SLOT_RUNNING  = 2'd2,
        SLOT_SLEEPING = 2'd3
    } slot_st_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN_CUR,
        ST_FIN_PICK,
        ST_OUT
    } fsm_t;

    typedef struct packed {
        logic              st_we;
        slot_st_t          st;
        logic              wk_we;
        logic [WAKE_W-1:0] wk;
    } mem_wr_t;

    typedef struct packed {
        slot_st_t          st;
        logic [WAKE_W-1:0] wk;
    } mem_rd_t;

endpackage

@@ hw/rtl/rrts_slot_mem.sv @@
// Slot table memories for slot state and wake time, with registered reads.
module rrts_slot_mem #(
    parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF,
    parameter int SLOT_W     = $clog2(TASK_SLOTS)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [SLOT_W-1:0]    rd_addr,
    output rrts_pkg::mem_rd_t    rd,
    input  logic [SLOT_W-1:0]    wr_addr,
    input  rrts_pkg::mem_wr_t    wr
);
    import rrts_pkg::*;

    slot_st_t          st_mem [TASK_SLOTS];
    logic [WAKE_W-1:0] wk_mem [TASK_SLOTS];

    logic [TASK_SLOTS-1:0] st_vld_reg;
    logic [TASK_SLOTS-1:0] wk_vld_reg;

    slot_st_t          rd_st_reg;
    logic [WAKE_W-1:0] rd_wk_reg;
    logic              rd_stv_reg;
    logic              rd_wkv_reg;
    logic              rd_zero_reg;

    always_ff @(posedge aclk) begin
        if (wr.st_we) begin
            st_mem[wr_addr] <= wr.st;
        end
        if (wr.wk_we) begin
            wk_mem[wr_addr] <= wr.wk;
        end
        if (rd_en) begin
            rd_st_reg   <= st_mem[rd_addr];
            rd_wk_reg   <= wk_mem[rd_addr];
            rd_stv_reg  <= st_vld_reg[rd_addr];
            rd_wkv_reg  <= wk_vld_reg[rd_addr];
            rd_zero_reg <= (rd_addr == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg <= '0;
            wk_vld_reg <= '0;
        end else begin
            if (wr.st_we) begin
                st_vld_reg[wr_addr] <= 1'b1;
            end
            if (wr.wk_we) begin
                wk_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // An entry never written reads as its reset value.
    always_comb begin
        if (rd_stv_reg) begin
            rd.st = rd_st_reg;
        end else begin
            rd.st = rd_zero_reg ? SLOT_RUNNING : SLOT_DEAD;
        end
        rd.wk = rd_wkv_reg ? rd_wk_reg : '0;
    end

endmodule

@@ hw/rtl/round_robin_task_scheduler.sv @@
// Top level of the round robin task scheduler over a table of task slots.
// Each input transaction carries one event: s_tuser holds the event code (tick,
// schedule, sleep active, kill active, create task) and s_tdata the sleep time.
// Each event yields exactly one output transaction on the m_ channel with the
// active slot, the previous slot, a refused flag and the slot given by create.
// Tick, create and refused events go straight to the output stage on acceptance.
// Schedule, sleep and kill first run a scan; the scan reads the other slots one
// per cycle through the read port of the slot memory, then writes back the old
// active slot and then the new one. When no other slot is ready only the old
// slot is written.
// A new event is accepted from the cycle after the previous result is loaded into
// the output register, so a result may wait there while the next event runs.
// When the receiver stalls, the finished result holds in the output register
// and the following event waits with its result until that register is free.
// Synchronous active-low reset makes slot 0 (idle) running, all other slots
// unused, clears uptime and sets the used slot count to one. No clearing pass
// is needed: per-entry valid bits supply the reset contents.
`include "round_robin_task_scheduler_macros.svh"

module round_robin_task_scheduler #(
    parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // sleep_seconds [15:0]
    input  logic [rrts_pkg::S_TDATA_W-1:0] s_tdata,
    // func [2:0]
    input  logic [rrts_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // active_slot [2:0], previous_slot [5:3], status [6], created_slot [9:7]
    output logic [rrts_pkg::M_TDATA_W-1:0] m_tdata
);
    import rrts_pkg::*;

    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

    fsm_t              state_reg, state_next;
    func_t             func_reg, func_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [SLOT_W-1:0] prev_reg, prev_next;
    logic [SLOT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] pend_addr_reg, pend_addr_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] pick_reg, pick_next;
    logic [WAKE_W-1:0] wake_reg, wake_next;
    logic              status_reg, status_next;
    logic [SLOT_W-1:0] created_reg, created_next;
    logic [SLOT_W-1:0] active_reg, active_next;
    logic [CNT_W-1:0]  slots_used_reg, slots_used_next;
    logic [WAKE_W-1:0] uptime_reg, uptime_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    func_t             func;
    logic [WAKE_W:0]   wake_sum;
    logic [WAKE_W-1:0] wake_sat;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    mem_rd_t           rd;
    logic [SLOT_W-1:0] wr_addr;
    mem_wr_t           wr;
    logic              issue;
    logic              wakeup;

    rrts_slot_mem #(
        .TASK_SLOTS (TASK_SLOTS),
        .SLOT_W     (SLOT_W)
    ) u_slot_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd      (rd),
        .wr_addr (wr_addr),
        .wr      (wr)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign func     = func_t'(s_tuser);
    assign wake_sum = {1'b0, uptime_reg} + (WAKE_W + 1)'(s_tdata);
    assign wake_sat = wake_sum[WAKE_W] ? '1 : wake_sum[WAKE_W-1:0];
    assign issue    = (rem_reg != '0);
    assign wakeup   = pend_reg && (rd.st == SLOT_SLEEPING) && (rd.wk < uptime_reg)
                      && (pend_addr_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            active_reg     <= '0;
            slots_used_reg <= CNT_W'(1);
            uptime_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            rem_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            slots_used_reg <= slots_used_next;
            uptime_reg     <= uptime_next;
            m_tvalid_reg   <= m_tvalid_next;
            pend_reg       <= pend_next;
            found_reg      <= found_next;
            rem_reg        <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        pick_reg      <= pick_next;
        wake_reg      <= wake_next;
        status_reg    <= status_next;
        created_reg   <= created_next;
        m_tdata_reg   <= m_tdata_next;
    end

    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        ptr_next        = ptr_reg;
        rem_next        = rem_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        wake_next       = wake_reg;
        status_next     = status_reg;
        created_next    = created_reg;
        active_next     = active_reg;
        slots_used_next = slots_used_reg;
        uptime_next     = uptime_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        rd_en           = 1'b0;
        rd_addr         = ptr_reg;
        wr_addr         = '0;
        wr              = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next      = func;
                    prev_next      = active_reg;
                    cur_next       = active_reg;
                    status_next    = 1'b0;
                    created_next   = '0;
                    wake_next      = wake_sat;
                    found_next     = 1'b0;
                    pend_next      = 1'b0;
                    ptr_next       = (active_reg == LAST_SLOT) ? '0 : active_reg + 1'b1;
                    rem_next       = CNT_W'(TASK_SLOTS - 1);
                    state_next     = ST_OUT;
                    unique case (func)
                        FUNC_TICK: begin
                            if (uptime_reg != '1) begin
                                uptime_next = uptime_reg + 1'b1;
                            end
                        end
                        FUNC_SCHEDULE, FUNC_KILL: begin
                            state_next = ST_SCAN;
                        end
                        FUNC_SLEEP: begin
                            if (active_reg == '0) begin
                                status_next = 1'b1;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        FUNC_CREATE: begin
                            if (slots_used_reg == CNT_W'(TASK_SLOTS)) begin
                                status_next = 1'b1;
                            end else begin
                                created_next    = SLOT_W'(slots_used_reg);
                                wr_addr         = SLOT_W'(slots_used_reg);
                                wr.st_we        = 1'b1;
                                wr.st           = SLOT_READY;
                                wr.wk_we        = 1'b1;
                                wr.wk           = '0;
                                slots_used_next = slots_used_reg + 1'b1;
                            end
                        end
                        default: begin
                            status_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                pend_next = issue;
                if (issue) begin
                    rd_en          = 1'b1;
                    rd_addr        = ptr_reg;
                    pend_addr_next = ptr_reg;
                    ptr_next       = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + 1'b1;
                    rem_next       = rem_reg - 1'b1;
                end
                if (wakeup) begin
                    wr_addr  = pend_addr_reg;
                    wr.st_we = 1'b1;
                    wr.st    = SLOT_READY;
                end
                if (pend_reg && !found_reg && (wakeup || rd.st == SLOT_READY)) begin
                    found_next = 1'b1;
                    pick_next  = pend_addr_reg;
                end
                if (pend_reg && !issue) begin
                    state_next = ST_FIN_CUR;
                end
            end

            ST_FIN_CUR: begin
                wr_addr  = cur_reg;
                wr.st_we = 1'b1;
                wr.wk_we = (func_reg == FUNC_SLEEP);
                wr.wk    = wake_reg;
                if (!found_reg) begin
                    wr.st      = SLOT_RUNNING;
                    state_next = ST_OUT;
                end else begin
                    case (func_reg)
                        FUNC_SLEEP: wr.st = SLOT_SLEEPING;
                        FUNC_KILL:  wr.st = SLOT_DEAD;
                        default:    wr.st = SLOT_READY;
                    endcase
                    state_next = ST_FIN_PICK;
                end
            end

            ST_FIN_PICK: begin
                wr_addr     = pick_reg;
                wr.st_we    = 1'b1;
                wr.st       = SLOT_RUNNING;
                active_next = pick_reg;
                state_next  = ST_OUT;
            end

            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {M_PAD_W'(0), OUT_SLOT_W'(created_reg), status_reg,
                                     OUT_SLOT_W'(prev_reg), OUT_SLOT_W'(active_reg)};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `RRTS_ASSERT(a_rw_apart, !(rd_en && (wr.st_we || wr.wk_we) && rd_addr == wr_addr), "slot memory read and write hit the same entry")
    `RRTS_ASSERT(a_used_range, slots_used_reg != '0 && slots_used_reg <= CNT_W'(TASK_SLOTS), "used slot count out of range")
    `RRTS_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_reg != ST_IDLE, "accepted event did not start")
    `RRTS_ASSERT_IMPL(a_pick_other, found_reg, pick_reg != cur_reg, "scan picked the active slot")

endmodule
